FILE: src/tablet_packet_decoder_unit_macros.svh
`ifndef TABLET_PACKET_DECODER_UNIT_MACROS_SVH
`define TABLET_PACKET_DECODER_UNIT_MACROS_SVH

// checked only out of reset
`define TPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked during reset too
`define TPD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: src/tpd_pkg.sv
package tpd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LOW_W   = 6;
  localparam int unsigned POS_W   = 12;
  localparam int unsigned CNT_W   = 3;
  localparam int unsigned WD_W    = 16;
  localparam int unsigned RELOAD_W = 15;
  localparam int unsigned PKT_LEN = 4;

  localparam logic [1:0] OP_BYTE = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_REQ  = 2'd2;

  localparam logic [1:0] CFG_HEADER_MASK    = 2'd0;
  localparam logic [1:0] CFG_IDLE_MASK      = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT_RELOAD = 2'd2;

  localparam logic [BYTE_W-1:0]   HEADER_MASK_RST    = 8'h80;
  localparam logic [BYTE_W-1:0]   IDLE_MASK_RST      = 8'h01;
  localparam logic [RELOAD_W-1:0] TIMEOUT_RELOAD_RST = 15'd20;

  typedef enum logic [1:0] {
    CMD_BYTE,
    CMD_TICK,
    CMD_REQ
  } cmd_e;

  typedef enum logic [1:0] {
    REP_PACKET,
    REP_TIMEOUT,
    REP_REQUEST
  } report_e;

  typedef struct packed {
    cmd_e              kind;
    logic [BYTE_W-1:0] data;
    logic              err;
    logic              header;
  } cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   header_mask;
    logic [BYTE_W-1:0]   idle_mask;
    logic [RELOAD_W-1:0] timeout_reload;
  } cfg_t;

endpackage

FILE: src/tpd_front.sv
module tpd_front (
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  op_i,
  input  logic [tpd_pkg::BYTE_W-1:0]  rx_byte_i,
  input  logic                        rx_error_i,
  input  logic [tpd_pkg::BYTE_W-1:0]  header_mask_i,
  input  logic                        q_ready_i,
  output logic                        q_push_o,
  output tpd_pkg::cmd_t               q_cmd_o
);

  logic known;

  always_comb begin
    known          = 1'b1;
    q_cmd_o.kind   = tpd_pkg::CMD_BYTE;
    q_cmd_o.data   = rx_byte_i;
    q_cmd_o.err    = rx_error_i;
    q_cmd_o.header = (rx_byte_i & header_mask_i) != '0;
    unique case (op_i)
      tpd_pkg::OP_BYTE: q_cmd_o.kind = tpd_pkg::CMD_BYTE;
      tpd_pkg::OP_TICK: q_cmd_o.kind = tpd_pkg::CMD_TICK;
      tpd_pkg::OP_REQ:  q_cmd_o.kind = tpd_pkg::CMD_REQ;
      default:          known = 1'b0;
    endcase
  end

  // drop unused op codes without queueing them
  assign in_ready_o = q_ready_i;
  assign q_push_o   = in_valid_i && q_ready_i && known;

endmodule

FILE: src/tpd_queue.sv
module tpd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tpd_pkg::cmd_t cmd_i,
  output logic          ready_o,
  output logic          valid_o,
  input  logic          pop_i,
  output tpd_pkg::cmd_t cmd_o
);

  tpd_pkg::cmd_t slot_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    count_q, count_d;
  logic          do_push, do_pop;

  assign ready_o = count_q != 2'd2;
  assign valid_o = count_q != 2'd0;
  assign cmd_o   = slot_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

FILE: src/tpd_back.sv
`include "tablet_packet_decoder_unit_macros.svh"

module tpd_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tpd_pkg::cfg_t               cfg_i,
  input  logic                        q_valid_i,
  input  tpd_pkg::cmd_t               q_cmd_i,
  output logic                        q_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  report_kind_o,
  output logic [tpd_pkg::POS_W-1:0]   pos_x_o,
  output logic [tpd_pkg::POS_W-1:0]   pos_y_o,
  output logic [tpd_pkg::BYTE_W-1:0]  event_code_o
);

  logic [tpd_pkg::LOW_W-1:0]  pb_q [tpd_pkg::PKT_LEN];
  logic [tpd_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [tpd_pkg::BYTE_W-1:0] pend_q, pend_d;
  logic [tpd_pkg::POS_W-1:0]  cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [tpd_pkg::POS_W-1:0]  last_x_q, last_x_d, last_y_q, last_y_d;
  logic [tpd_pkg::BYTE_W-1:0] last_ev_q, last_ev_d;
  logic                       idle_q, idle_d;
  logic [tpd_pkg::WD_W-1:0]   wd_q, wd_d;

  logic                       out_valid_q, out_valid_d;
  tpd_pkg::report_e           kind_q, kind_d;
  logic [tpd_pkg::POS_W-1:0]  ox_q, ox_d, oy_q, oy_d;
  logic [tpd_pkg::BYTE_W-1:0] oev_q, oev_d;

  logic                       go, result, store;
  logic [tpd_pkg::CNT_W-1:0]  cnt_inc;
  logic [tpd_pkg::POS_W-1:0]  new_x, new_y;
  logic [tpd_pkg::BYTE_W-1:0] new_ev;

  assign go      = q_valid_i && (!out_valid_q || out_ready_i);
  assign q_pop_o = go;
  assign store   = go && q_cmd_i.kind == tpd_pkg::CMD_BYTE && cnt_q < 3'(tpd_pkg::PKT_LEN);
  assign cnt_inc = cnt_q + 3'd1;
  // the fourth byte is still in flight: take Y high from the item itself
  assign new_x   = {pb_q[1], pb_q[0]};
  assign new_y   = {q_cmd_i.data[tpd_pkg::LOW_W-1:0], pb_q[2]};
  assign new_ev  = pend_q | cfg_i.idle_mask;

  always_comb begin
    cnt_d     = cnt_q;
    pend_d    = pend_q;
    cur_x_d   = cur_x_q;
    cur_y_d   = cur_y_q;
    last_x_d  = last_x_q;
    last_y_d  = last_y_q;
    last_ev_d = last_ev_q;
    idle_d    = idle_q;
    wd_d      = wd_q;
    result    = 1'b0;
    kind_d    = kind_q;
    ox_d      = ox_q;
    oy_d      = oy_q;
    oev_d     = oev_q;
    if (go) begin
      unique case (q_cmd_i.kind)
        tpd_pkg::CMD_BYTE: begin
          idle_d = 1'b0;
          wd_d   = {1'b0, cfg_i.timeout_reload};
          cnt_d  = cnt_inc;
          if (q_cmd_i.err) begin
            cnt_d  = '0;
            pend_d = '0;
          end else if (q_cmd_i.header) begin
            pend_d = q_cmd_i.data;
            cnt_d  = '0;
          end else if (cnt_inc == 3'(tpd_pkg::PKT_LEN) &&
                       (pend_q & cfg_i.header_mask) != '0) begin
            cur_x_d = new_x;
            cur_y_d = new_y;
            if (new_x != last_x_q || new_y != last_y_q || new_ev != last_ev_q) begin
              last_x_d  = new_x;
              last_y_d  = new_y;
              last_ev_d = new_ev;
              result    = 1'b1;
              kind_d    = tpd_pkg::REP_PACKET;
              ox_d      = new_x;
              oy_d      = new_y;
              oev_d     = new_ev;
            end
            pend_d = '0;
            cnt_d  = '0;
          end else if (cnt_inc > 3'(tpd_pkg::PKT_LEN)) begin
            cnt_d  = '0;
            pend_d = '0;
          end
        end
        tpd_pkg::CMD_TICK: begin
          if (!idle_q) begin
            wd_d = wd_q - 16'd1;
            if (wd_q[tpd_pkg::WD_W-1]) begin
              idle_d    = 1'b1;
              last_ev_d = last_ev_q & ~cfg_i.idle_mask;
              result    = 1'b1;
              kind_d    = tpd_pkg::REP_TIMEOUT;
              ox_d      = cur_x_q;
              oy_d      = cur_y_q;
              oev_d     = last_ev_q & ~cfg_i.idle_mask;
            end
          end
        end
        tpd_pkg::CMD_REQ: begin
          result = 1'b1;
          kind_d = tpd_pkg::REP_REQUEST;
          ox_d   = cur_x_q;
          oy_d   = cur_y_q;
          oev_d  = pend_q;
        end
        default: ;
      endcase
    end
    if (go && result) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      pend_q      <= '0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      last_x_q    <= '0;
      last_y_q    <= '0;
      last_ev_q   <= '0;
      idle_q      <= 1'b1;
      wd_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      last_x_q    <= last_x_d;
      last_y_q    <= last_y_d;
      last_ev_q   <= last_ev_d;
      idle_q      <= idle_d;
      wd_q        <= wd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    ox_q   <= ox_d;
    oy_q   <= oy_d;
    oev_q  <= oev_d;
    if (store) begin
      pb_q[cnt_q[1:0]] <= q_cmd_i.data[tpd_pkg::LOW_W-1:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign report_kind_o = kind_q;
  assign pos_x_o       = ox_q;
  assign pos_y_o       = oy_q;
  assign event_code_o  = oev_q;

  `TPD_ASSERT(a_cnt_range, cnt_q <= 3'(tpd_pkg::PKT_LEN), "byte count beyond packet length")
  `TPD_ASSERT(a_idle_tick_silent, go && idle_q && q_cmd_i.kind == tpd_pkg::CMD_TICK |-> !result, "tick reported while idle")
  `TPD_ASSERT(a_timeout_idle, go && result && kind_d == tpd_pkg::REP_TIMEOUT |=> idle_q, "timeout report left block active")
  `TPD_ASSERT(a_packet_clears, go && result && kind_d == tpd_pkg::REP_PACKET |=> cnt_q == '0 && pend_q == '0, "packet report left header pending")
  `TPD_ASSERT_ALWAYS(a_no_pop_stalled, out_valid_q && !out_ready_i |-> !q_pop_o, "item taken while result stalled")

endmodule

FILE: src/tablet_packet_decoder_unit.sv
// channel  direction  handshake                 payload
// in       input      in_valid_i / in_ready_o   op_i, rx_byte_i, rx_error_i
// out      output     out_valid_o / out_ready_i report_kind_o, pos_x_o, pos_y_o, event_code_o
// cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One item per cycle sustained while the output is not stalled; an accepted item waits in a
// two-entry queue until the back end takes it, and its result is then registered on the output.
// The back end updates all decoder state as it takes each item.
// Reset is asynchronous and active low; no clearing pass, the block accepts items at once.
// A stalled result holds the back end; the queue keeps accepting until both entries fill.
// Configuration writes are always taken.
module tablet_packet_decoder_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [1:0]                            op_i,
  input  logic [tpd_pkg::BYTE_W-1:0]            rx_byte_i,
  input  logic                                  rx_error_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [1:0]                            report_kind_o,
  output logic [tpd_pkg::POS_W-1:0]             pos_x_o,
  output logic [tpd_pkg::POS_W-1:0]             pos_y_o,
  output logic [tpd_pkg::BYTE_W-1:0]            event_code_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [1:0]                            cfg_index_i,
  input  logic [tpd_pkg::RELOAD_W-1:0]          cfg_data_i
);

  tpd_pkg::cfg_t cfg_q;
  tpd_pkg::cmd_t push_cmd, pop_cmd;
  logic          q_ready, q_push, q_valid, q_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_mask    <= tpd_pkg::HEADER_MASK_RST;
      cfg_q.idle_mask      <= tpd_pkg::IDLE_MASK_RST;
      cfg_q.timeout_reload <= tpd_pkg::TIMEOUT_RELOAD_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tpd_pkg::CFG_HEADER_MASK:    cfg_q.header_mask    <= cfg_data_i[tpd_pkg::BYTE_W-1:0];
        tpd_pkg::CFG_IDLE_MASK:      cfg_q.idle_mask      <= cfg_data_i[tpd_pkg::BYTE_W-1:0];
        tpd_pkg::CFG_TIMEOUT_RELOAD: cfg_q.timeout_reload <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tpd_front u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .rx_byte_i     (rx_byte_i),
    .rx_error_i    (rx_error_i),
    .header_mask_i (cfg_q.header_mask),
    .q_ready_i     (q_ready),
    .q_push_o      (q_push),
    .q_cmd_o       (push_cmd)
  );

  tpd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .cmd_o   (pop_cmd)
  );

  tpd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_valid_i     (q_valid),
    .q_cmd_i       (pop_cmd),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .report_kind_o (report_kind_o),
    .pos_x_o       (pos_x_o),
    .pos_y_o       (pos_y_o),
    .event_code_o  (event_code_o)
  );

endmodule

FILE: tb/sv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tpd_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;

  typedef struct {
    report_e             kind;
    logic [POS_W-1:0]    x;
    logic [POS_W-1:0]    y;
    logic [BYTE_W-1:0]   ev;
  } report_t;

  class report_tracker;
    logic [BYTE_W-1:0]   hdr_mask;
    logic [BYTE_W-1:0]   idle_mask;
    logic [RELOAD_W-1:0] reload;
    logic [LOW_W-1:0]    stash [PKT_LEN];
    logic [CNT_W-1:0]    count;
    logic [BYTE_W-1:0]   pend_ev;
    logic [POS_W-1:0]    cur_x;
    logic [POS_W-1:0]    cur_y;
    logic [POS_W-1:0]    last_x;
    logic [POS_W-1:0]    last_y;
    logic [BYTE_W-1:0]   last_ev;
    logic                idle;
    logic [WD_W-1:0]     wdog;
    report_t             reports_due [$];
    int unsigned         errors;
    int unsigned         seen [3];

    function new();
      hdr_mask  = HEADER_MASK_RST;
      idle_mask = IDLE_MASK_RST;
      reload    = TIMEOUT_RELOAD_RST;
      foreach (stash[i]) stash[i] = '0;
      count   = '0;
      pend_ev = '0;
      cur_x   = '0;
      cur_y   = '0;
      last_x  = '0;
      last_y  = '0;
      last_ev = '0;
      idle    = 1'b1;
      wdog    = '0;
      errors  = 0;
      foreach (seen[i]) seen[i] = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [RELOAD_W-1:0] val);
      case (idx)
        CFG_HEADER_MASK:    hdr_mask = val[BYTE_W-1:0];
        CFG_IDLE_MASK:      idle_mask = val[BYTE_W-1:0];
        CFG_TIMEOUT_RELOAD: reload = val;
        default: ;
      endcase
    endfunction

    function void push_report(report_e kind, logic [BYTE_W-1:0] ev);
      report_t r;
      r.kind = kind;
      r.x    = cur_x;
      r.y    = cur_y;
      r.ev   = ev;
      reports_due.push_back(r);
    endfunction

    function void predict_item(logic [1:0] op, logic [BYTE_W-1:0] b, logic err);
      logic neg;
      case (op)
        OP_BYTE: begin
          idle = 1'b0;
          wdog = {1'b0, reload};
          if (count < PKT_LEN) stash[count[1:0]] = b[LOW_W-1:0];
          count = count + 1'b1;
          if (err) begin
            count   = '0;
            pend_ev = '0;
          end else if ((b & hdr_mask) != 0) begin
            pend_ev = b;
            count   = '0;
          end else if (count == PKT_LEN && (pend_ev & hdr_mask) != 0) begin
            pend_ev = pend_ev | idle_mask;
            cur_x   = {stash[1], stash[0]};
            cur_y   = {stash[3], stash[2]};
            if (cur_x != last_x || cur_y != last_y || pend_ev != last_ev) begin
              last_x  = cur_x;
              last_y  = cur_y;
              last_ev = pend_ev;
              push_report(REP_PACKET, last_ev);
            end
            pend_ev = '0;
            count   = '0;
          end
          if (count > PKT_LEN) begin
            count   = '0;
            pend_ev = '0;
          end
        end
        OP_TICK: begin
          if (!idle) begin
            neg  = wdog[WD_W-1];
            wdog = wdog - 1'b1;
            if (neg) begin
              idle    = 1'b1;
              last_ev = last_ev & ~idle_mask;
              push_report(REP_TIMEOUT, last_ev);
            end
          end
        end
        OP_REQ: push_report(REP_REQUEST, pend_ev);
        default: ;
      endcase
    endfunction

    function void check_report(logic [1:0] kind, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                               logic [BYTE_W-1:0] ev);
      report_t r;
      if (reports_due.size() == 0) begin
        errors++;
        $error("unexpected report: kind %0d x %0d y %0d event %0h", kind, x, y, ev);
        return;
      end
      r = reports_due.pop_front();
      seen[int'(r.kind)]++;
      if (kind !== r.kind) begin
        errors++;
        $error("report_kind: expected %0d, got %0d", r.kind, kind);
      end
      if (x !== r.x) begin
        errors++;
        $error("pos_x: expected %0d, got %0d", r.x, x);
      end
      if (y !== r.y) begin
        errors++;
        $error("pos_y: expected %0d, got %0d", r.y, y);
      end
      if (ev !== r.ev) begin
        errors++;
        $error("event_code: expected %0h, got %0h", r.ev, ev);
      end
    endfunction

    function int unsigned pending();
      return reports_due.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready_o;
  logic [1:0]          op = OP_BYTE;
  logic [BYTE_W-1:0]   rx_byte = '0;
  logic                rx_error = 1'b0;
  logic                out_valid_o;
  logic                out_ready = 1'b0;
  logic [1:0]          report_kind_o;
  logic [POS_W-1:0]    pos_x_o;
  logic [POS_W-1:0]    pos_y_o;
  logic [BYTE_W-1:0]   event_code_o;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready_o;
  logic [1:0]          cfg_index = CFG_HEADER_MASK;
  logic [RELOAD_W-1:0] cfg_data = '0;

  report_tracker sb = new();
  int unsigned   send_idle_pct = 0;
  int unsigned   stall_pct = 0;
  int unsigned   items_sent = 0;

  tablet_packet_decoder_unit u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready_o),
    .op_i          (op),
    .rx_byte_i     (rx_byte),
    .rx_error_i    (rx_error),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready),
    .report_kind_o (report_kind_o),
    .pos_x_o       (pos_x_o),
    .pos_y_o       (pos_y_o),
    .event_code_o  (event_code_o),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid_o && out_ready)
      sb.check_report(report_kind_o, pos_x_o, pos_y_o, event_code_o);
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_item(input logic [1:0] o, input logic [BYTE_W-1:0] b, input logic e);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= o;
    rx_byte  <= b;
    rx_error <= e;
    do @(posedge clk); while (!in_ready_o);
    sb.predict_item(o, b, e);
    if (o != OP_NONE) items_sent++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [RELOAD_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready_o);
    sb.set_register(idx, val);
  endtask

  task automatic drain();
    int unsigned guard;
    guard = 0;
    in_valid <= 1'b0;
    stall_pct = 0;
    while (sb.pending() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [BYTE_W-1:0] make_header(logic [BYTE_W-1:0] hm);
    logic [BYTE_W-1:0] b;
    int k;
    b = BYTE_W'($urandom);
    if (hm != 0) begin
      do k = $urandom_range(BYTE_W-1); while (!hm[k]);
      b[k] = 1'b1;
    end
    return b;
  endfunction

  function automatic logic [BYTE_W-1:0] make_data(logic [BYTE_W-1:0] hm);
    logic [BYTE_W-1:0] b;
    b = BYTE_W'($urandom);
    return b & ~hm;
  endfunction

  task automatic run_phase(input int unsigned mode, input logic [BYTE_W-1:0] hm,
                           input logic [BYTE_W-1:0] im, input logic [RELOAD_W-1:0] rl,
                           input int unsigned quota);
    logic [BYTE_W-1:0] hdr;
    logic [BYTE_W-1:0] body [PKT_LEN];
    logic              have_pkt;
    int unsigned       start;
    int unsigned       r;
    int unsigned       bad;
    int unsigned       n;
    write_reg(CFG_HEADER_MASK, {{(RELOAD_W-BYTE_W){1'b0}}, hm});
    write_reg(CFG_IDLE_MASK, {{(RELOAD_W-BYTE_W){1'b0}}, im});
    write_reg(CFG_TIMEOUT_RELOAD, rl);
    cfg_valid <= 1'b0;
    case (mode)
      1: begin send_idle_pct = 68; stall_pct = 0; end
      2: begin send_idle_pct = 0; stall_pct = 68; end
      3: begin send_idle_pct = 7; stall_pct = 7; end
      default: begin send_idle_pct = 0; stall_pct = 0; end
    endcase
    have_pkt = 1'b0;
    hdr = '0;
    start = items_sent;
    while (items_sent - start < quota) begin
      r = $urandom_range(99);
      if (r < 55) begin
        if (!have_pkt || $urandom_range(3) != 0) begin
          hdr = make_header(hm);
          foreach (body[i]) body[i] = make_data(hm);
          have_pkt = 1'b1;
        end
        bad = ($urandom_range(19) == 0) ? $urandom_range(PKT_LEN) : PKT_LEN + 1;
        send_item(OP_BYTE, hdr, bad == 0);
        foreach (body[i]) send_item(OP_BYTE, body[i], bad == i + 1);
      end else if (r < 70) begin
        n = (rl < 40) ? $urandom_range(1, int'(rl) + 4) : $urandom_range(1, 30);
        repeat (n) send_item(OP_TICK, BYTE_W'($urandom), 1'($urandom_range(1)));
      end else if (r < 80) begin
        send_item(OP_REQ, BYTE_W'($urandom), 1'($urandom_range(1)));
      end else if (r < 92) begin
        send_item(OP_BYTE, BYTE_W'($urandom), $urandom_range(4) == 0);
      end else if (r < 96) begin
        n = $urandom_range(5, 7);
        repeat (n) send_item(OP_BYTE, make_data(hm), 1'b0);
      end else begin
        send_item(OP_NONE, BYTE_W'($urandom), 1'($urandom_range(1)));
      end
    end
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // short watchdog so the timeout shows up early
    write_reg(CFG_TIMEOUT_RELOAD, '0);
    cfg_valid <= 1'b0;
    send_item(OP_REQ, 8'h00, 1'b0);
    send_item(OP_TICK, 8'hff, 1'b1);
    send_item(OP_NONE, 8'hff, 1'b1);
    send_item(OP_BYTE, 8'hc0, 1'b0);
    repeat (PKT_LEN) send_item(OP_BYTE, 8'h3f, 1'b0);
    send_item(OP_BYTE, 8'hff, 1'b0);
    repeat (PKT_LEN) send_item(OP_BYTE, 8'h00, 1'b0);
    repeat (PKT_LEN + 1) send_item(OP_BYTE, 8'h7f, 1'b0);
    send_item(OP_BYTE, 8'h80, 1'b0);
    send_item(OP_BYTE, 8'hff, 1'b1);
    send_item(OP_REQ, 8'hff, 1'b1);
    repeat (3) send_item(OP_TICK, 8'h00, 1'b0);
    drain();

    run_phase(0, HEADER_MASK_RST, IDLE_MASK_RST, TIMEOUT_RELOAD_RST, 235);
    run_phase(1, 8'hff, 8'hff, 15'd0, 235);
    run_phase(2, 8'h00, 8'h00, 15'd32767, 235);
    run_phase(3, 8'h40, 8'h02, 15'd3, 235);
    run_phase(0, BYTE_W'($urandom), BYTE_W'($urandom), RELOAD_W'($urandom_range(0, 40)), 235);
    run_phase(1, 8'h01, 8'h80, 15'd1, 235);
    run_phase(2, BYTE_W'($urandom), BYTE_W'($urandom), RELOAD_W'($urandom_range(0, 32767)),
              235);
    run_phase(3, 8'hc0, 8'h81, 15'd10, 235);

    if (sb.pending() != 0) $error("%0d reports never arrived", sb.pending());
    $display("Covered %0d input items over nine register settings and four pacing modes.",
             items_sent);
    $display("Checked %0d packet, %0d timeout and %0d request reports.",
             sb.seen[0], sb.seen[1], sb.seen[2]);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
